// ----- rtl/kcl_pkg.sv -----
// Package for the keypad code lock: outcome codes and the tone-to-digit mapping.
// No dependencies; imported by every module of the block.
package kcl_pkg;

    // Tone decoder code that stands for the digit zero.
    localparam logic [3:0] TONE_ZERO = 4'd10;

    // Outcome of one keypad transaction.
    typedef enum logic [2:0] {
        OUT_STORED   = 3'd0,
        OUT_MATCHED  = 3'd1,
        OUT_ERROR    = 3'd2,
        OUT_UNLOCKED = 3'd3,
        OUT_FULL     = 3'd4
    } outcome_t;

    // Map the tone code to a digit; only code ten is translated.
    function automatic logic [3:0] map_digit(input logic [3:0] tone);
        logic [3:0] result;
        begin
            result = (tone == TONE_ZERO) ? 4'd0 : tone;
            return result;
        end
    endfunction

endpackage

// ----- rtl/kcl_store.sv -----
// Code store of the keypad code lock: one write port and one registered read port.
// A write to the address being read is forwarded to the read register. Uses kcl_pkg.
module kcl_store
    import kcl_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [3:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [3:0]    rd_data
);

    logic [3:0] mem [DEPTH];
    logic [3:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port with write forwarding.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/kcl_step.sv -----
// Step logic of the keypad code lock: works out the outcome and the next counters
// for one digit from the current state and the prefetched expected digit. Uses kcl_pkg.
module kcl_step
    import kcl_pkg::*;
#(
    parameter int MAX_DIGITS = 32,
    parameter int CW         = 6,
    parameter int AW         = 5
)
(
    input  logic [3:0]    digit,
    input  logic          program_held,
    input  logic          was_programming,
    input  logic [CW-1:0] code_length,
    input  logic [CW-1:0] match_position,
    input  logic [3:0]    expected,
    output outcome_t      outcome,
    output logic [CW-1:0] length_next,
    output logic [CW-1:0] position_next,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr
);

    logic [CW-1:0] length_base;
    logic [CW-1:0] position_base;
    logic [CW-1:0] position_inc;

    // Counters as seen after the start of programming clears them.
    assign length_base   = was_programming ? code_length : '0;
    assign position_base = was_programming ? match_position : '0;
    assign position_inc  = match_position + 1'b1;
    assign wr_addr       = length_base[AW-1:0];

    // Programming appends the digit unless full; else it is checked against the code.
    always_comb
    begin
        outcome       = OUT_ERROR;
        length_next   = code_length;
        position_next = '0;
        wr_en         = 1'b0;
        if (program_held)
        begin
            position_next = position_base;
            if (length_base < CW'(MAX_DIGITS))
            begin
                wr_en       = 1'b1;
                length_next = length_base + 1'b1;
                outcome     = OUT_STORED;
            end
            else
            begin
                length_next = length_base;
                outcome     = OUT_FULL;
            end
        end
        else if ((code_length == '0) || (match_position >= code_length))
        begin
            outcome = OUT_ERROR;
        end
        else if (expected == digit)
        begin
            if (position_inc == code_length)
            begin
                outcome = OUT_UNLOCKED;
            end
            else
            begin
                position_next = position_inc;
                outcome       = OUT_MATCHED;
            end
        end
        else
        begin
            outcome = OUT_ERROR;
        end
    end

endmodule

// ----- rtl/keypad_code_lock_top.sv -----
// Keypad code lock top level. It takes one keypad transaction per clock cycle while
// key_stall is low, and delivers each result through an input register and a result
// register. The store digit expected at the current match position is read ahead into
// a register as each transaction advances, so that each compare needs no memory
// access. Depends on kcl_pkg, kcl_store and kcl_step.
module keypad_code_lock_top
    import kcl_pkg::*;
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    input  logic [3:0] tone_code,
    input  logic       program_held,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] digit_value,
    output logic [2:0] outcome,
    output logic [5:0] stored_length,
    output logic [5:0] match_count
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [3:0]    s1_digit_reg;
    logic          s1_prog_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    logic [3:0]    res_digit_reg;
    outcome_t      res_outcome_reg;
    logic [CW-1:0] res_length_reg;
    logic [CW-1:0] res_position_reg;
    logic [CW-1:0] code_length_reg;
    logic [CW-1:0] match_position_reg;
    logic          was_programming_reg;
    logic          key_accept;
    logic          advance;
    logic [3:0]    expected;
    outcome_t      step_outcome;
    logic [CW-1:0] length_next;
    logic [CW-1:0] position_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // Handshake: the input register advances whenever the result register is free.
    assign advance    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign key_stall  = s1_valid_reg && !advance;
    assign key_accept = key_valid && !key_stall;

    assign s1_valid_next  = key_accept || (s1_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
            code_length_reg     <= '0;
            match_position_reg  <= '0;
            was_programming_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                code_length_reg     <= length_next;
                match_position_reg  <= position_next;
                was_programming_reg <= s1_prog_reg;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (key_accept)
        begin
            s1_digit_reg <= map_digit(tone_code);
            s1_prog_reg  <= program_held;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_digit_reg    <= s1_digit_reg;
            res_outcome_reg  <= step_outcome;
            res_length_reg   <= length_next;
            res_position_reg <= position_next;
        end
    end

    // Step logic for the transaction held in the input register.
    kcl_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .CW         (CW),
        .AW         (AW)
    ) u_step (
        .digit           (s1_digit_reg),
        .program_held    (s1_prog_reg),
        .was_programming (was_programming_reg),
        .code_length     (code_length_reg),
        .match_position  (match_position_reg),
        .expected        (expected),
        .outcome         (step_outcome),
        .length_next     (length_next),
        .position_next   (position_next),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr)
    );

    // Code store; the read fetches the digit at the next match position.
    kcl_store #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en && advance),
        .wr_addr (wr_addr),
        .wr_data (s1_digit_reg),
        .rd_en   (advance),
        .rd_addr (position_next[AW-1:0]),
        .rd_data (expected)
    );

    // Outputs, with counts masked to the port width.
    assign res_valid     = res_valid_reg;
    assign digit_value   = res_digit_reg;
    assign outcome       = res_outcome_reg;
    assign stored_length = 6'(res_length_reg);
    assign match_count   = 6'(res_position_reg);

endmodule

// ----- rtl/kcl_checker.sv -----
// Port-level checker for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_top.
module kcl_checker
    import kcl_pkg::*;
#(
    parameter int MAX_DIGITS = 32
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [2:0] outcome,
    input logic [5:0] match_count
);

    // A stalled result stays offered with the same outcome.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(outcome))
        else $error("stalled result changed or was withdrawn");

    // Unlock restarts the entry attempt.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (outcome == OUT_UNLOCKED) |-> (match_count == 6'd0))
        else $error("match count not cleared on unlock");

    // An error restarts the entry attempt.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (outcome == OUT_ERROR) |-> (match_count == 6'd0))
        else $error("match count not cleared on error");

    // A partial match always has at least one matched digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (outcome == OUT_MATCHED) && (MAX_DIGITS < 64)
            |-> (match_count != 6'd0))
        else $error("partial match with zero matched digits");

endmodule

bind keypad_code_lock_top kcl_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_kcl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .outcome     (outcome),
    .match_count (match_count)
);

// ----- tb/keypad_code_lock_top_tb.sv -----
// Self-checking testbench for keypad_code_lock_top: directed and random keypad transactions,
// with results predicted cycle-free and compared in order. Depends on kcl_pkg and the
// keypad_code_lock_top RTL.
module keypad_code_lock_top_tb;
    import kcl_pkg::*;

    localparam int LOCK_DIGITS = 32;
    localparam int RANDOM_KEYS = 1050;

    // One expected result transaction.
    typedef struct {
        logic [3:0] digit;
        outcome_t   outcome;
        logic [5:0] stored_len;
        logic [5:0] match_cnt;
    } lock_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       key_valid;
    logic       key_stall;
    logic [3:0] tone_code;
    logic       program_held;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [3:0] digit_value;
    logic [2:0] outcome;
    logic [5:0] stored_length;
    logic [5:0] match_count;

    // Shadow copy of the lock state.
    logic [3:0] stored_digits [LOCK_DIGITS];
    int         code_len;
    int         match_pos;
    logic       programming;

    lock_result_t pending_results [$];
    logic [3:0]   code_tones [40];
    bit           steady;
    int           sent_count;
    int           checked_count;
    int           unlock_count;
    int           full_count;
    int           error_count;

    keypad_code_lock_top #(.MAX_DIGITS(LOCK_DIGITS)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .tone_code     (tone_code),
        .program_held  (program_held),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .digit_value   (digit_value),
        .outcome       (outcome),
        .stored_length (stored_length),
        .match_count   (match_count)
    );

    always #1 clk = ~clk;

    // Work out the result of one accepted keypad transaction and update the shadow state.
    function automatic void lock_predict(input logic [3:0] tone, input logic prog);
        lock_result_t res;
        logic [3:0]   digit;
        digit = (tone == TONE_ZERO) ? 4'd0 : tone;
        if (prog) begin
            if (!programming) begin
                code_len  = 0;
                match_pos = 0;
            end
            if (code_len < LOCK_DIGITS) begin
                stored_digits[code_len] = digit;
                code_len++;
                res.outcome = OUT_STORED;
            end
            else begin
                res.outcome = OUT_FULL;
                full_count++;
            end
        end
        else if (code_len == 0 || match_pos >= code_len) begin
            match_pos   = 0;
            res.outcome = OUT_ERROR;
        end
        else if (stored_digits[match_pos] == digit) begin
            match_pos++;
            if (match_pos == code_len) begin
                match_pos   = 0;
                res.outcome = OUT_UNLOCKED;
                unlock_count++;
            end
            else begin
                res.outcome = OUT_MATCHED;
            end
        end
        else begin
            match_pos   = 0;
            res.outcome = OUT_ERROR;
        end
        programming    = prog;
        res.digit      = digit;
        res.stored_len = 6'(code_len);
        res.match_cnt  = 6'(match_pos);
        pending_results.push_back(res);
    endfunction

    // Send one keypad transaction; entered and left at a falling edge.
    task automatic send_key(input logic [3:0] tone, input logic prog);
        if (!steady && $urandom_range(0, 99) < 33) begin
            key_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        key_valid    = 1'b1;
        tone_code    = tone;
        program_held = prog;
        forever begin
            @(posedge clk);
            if (!key_stall)
                break;
        end
        lock_predict(tone, prog);
        sent_count++;
        @(negedge clk);
    endtask

    // Program the first len entries of code_tones as the new code.
    task automatic program_code(input int len);
        for (int i = 0; i < len; i++)
            send_key(code_tones[i], 1'b1);
    endtask

    // Enter the code; a wrong digit at miss_at ends the attempt early.
    task automatic enter_code(input int len, input int miss_at);
        logic [3:0] tone;
        for (int i = 0; i < len; i++) begin
            tone = code_tones[i];
            if (tone == TONE_ZERO || tone == 4'd0)
                tone = $urandom_range(0, 1) ? TONE_ZERO : 4'd0;
            if (i == miss_at) begin
                send_key(tone ^ 4'($urandom_range(1, 15)), 1'b0);
                break;
            end
            send_key(tone, 1'b0);
        end
    endtask

    // Digits with no code stored are all errors.
    task automatic test_empty_code();
        send_key(4'd0, 1'b0);
        send_key(4'd15, 1'b0);
        send_key(TONE_ZERO, 1'b0);
    endtask

    // Program a code using the zero tone and two unmapped codes, then unlock.
    task automatic test_program_and_unlock();
        code_tones[0] = TONE_ZERO;
        code_tones[1] = 4'd15;
        code_tones[2] = 4'd11;
        code_tones[3] = 4'd0;
        program_code(4);
        enter_code(4, -1);
    endtask

    // A wrong digit part way through clears the match, and a retry still unlocks.
    task automatic test_miss_and_retry();
        send_key(TONE_ZERO, 1'b0);
        send_key(4'd5, 1'b0);
        send_key(4'd0, 1'b0);
        send_key(4'd15, 1'b0);
        send_key(4'd11, 1'b0);
        send_key(TONE_ZERO, 1'b0);
    endtask

    // A fresh programming press replaces the code; a one-digit code unlocks at once.
    task automatic test_reprogram();
        send_key(4'd3, 1'b1);
        send_key(4'd3, 1'b0);
        send_key(4'd7, 1'b1);
        send_key(4'd12, 1'b1);
        send_key(4'd7, 1'b0);
        send_key(4'd12, 1'b0);
        send_key(4'd1, 1'b0);
    endtask

    // Random sessions: mostly well-formed programming and entry, some long codes
    // that overflow the store, and some noise.
    task automatic test_random_sessions(input int target);
        int pick;
        int len;
        int attempts;
        while (sent_count < target) begin
            steady = (sent_count >= 500 && sent_count < 650);
            pick   = $urandom_range(0, 99);
            if (pick < 70) begin
                len = (pick < 6) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    code_tones[i] = 4'($urandom_range(0, 15));
                program_code(len);
                if (len > LOCK_DIGITS)
                    len = LOCK_DIGITS;
                attempts = (pick < 6) ? 1 : $urandom_range(1, 3);
                for (int a = 0; a < attempts; a++) begin
                    if ($urandom_range(0, 99) < 60 || pick < 6)
                        enter_code(len, -1);
                    else
                        enter_code(len, $urandom_range(0, len - 1));
                end
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
    endtask

    // The receiving side stalls at random, except during the steady stretch.
    always @(negedge clk) begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= !steady && ($urandom_range(0, 99) < 33);
    end

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge clk) begin : result_check
        lock_result_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction waiting");
                error_count++;
            end
            else begin
                want = pending_results.pop_front();
                checked_count++;
                if (digit_value !== want.digit) begin
                    $error("digit_value: expected %0d, got %0d", want.digit, digit_value);
                    error_count++;
                end
                if (outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                    error_count++;
                end
                if (stored_length !== want.stored_len) begin
                    $error("stored_length: expected %0d, got %0d",
                           want.stored_len, stored_length);
                    error_count++;
                end
                if (match_count !== want.match_cnt) begin
                    $error("match_count: expected %0d, got %0d", want.match_cnt, match_count);
                    error_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        rst_n        = 1'b0;
        key_valid    = 1'b0;
        tone_code    = 4'd0;
        program_held = 1'b0;
        steady       = 1'b0;
        code_len     = 0;
        match_pos    = 0;
        programming  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_code();
        test_program_and_unlock();
        test_miss_and_retry();
        test_reprogram();
        test_random_sessions(sent_count + RANDOM_KEYS);

        key_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d of %0d keypad transactions: %0d unlocks, %0d store-full results.",
                 checked_count, sent_count, unlock_count, full_count);
        if (error_count == 0)
            $display("keypad_code_lock_top test passed");
        else
            $display("keypad_code_lock_top test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #400000;
        $display("keypad_code_lock_top test failed");
        $finish;
    end

endmodule
